// ===== rtl/itaf_pkg.sv =====
// shared types, codes and character tables for the integer to ascii formatter
`default_nettype none

package itaf_pkg;

   // default width at which a value is read
   localparam int VALUE_WIDTH_DEF = 32;

   // width of the running character count
   localparam int COUNT_WIDTH = 32;

   // ascii codes used directly
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // digit tables, index is the digit value
   localparam logic [7:0] HEX_LOWER [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };
   localparam logic [7:0] HEX_UPPER [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   // format selector codes
   typedef enum logic [1:0] {
      FMT_SDEC = 2'd0,
      FMT_UDEC = 2'd1,
      FMT_HEXL = 2'd2,
      FMT_HEXU = 2'd3
   } fmt_type;

   // input beat
   typedef struct packed {
      fmt_type     action;
      logic [31:0] value;
   } req_type;

   // result beat, one per character
   typedef struct packed {
      logic [7:0]             char_code;
      logic                   last_char;
      logic [COUNT_WIDTH-1:0] total_emitted;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      logic    negative;
      fmt_type fmt;
   } job_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_CONV = 2'd1,
      ST_NORM = 2'd2,
      ST_EMIT = 2'd3
   } back_state_type;

   // ascii code of one digit
   function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
      digit_char = upper ? HEX_UPPER[digit] : HEX_LOWER[digit];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_ascii_formatter.sv =====
// top level of the integer to ascii formatter
//
//   channel   direction  handshake            beat
//   req_      in         req_valid/req_stall  req_type: action, value
//   rsp_      out        rsp_valid/rsp_stall  rsp_type: char_code, last_char, total_emitted
//
// the back end double dabble unit, four bits per cycle, converts decimal values; hex skips it.
// a two entry job queue lets the front accept values while the back still converts.
// reset is synchronous: it empties the queue, drops rsp_valid and clears the count.
// a stalled output beat holds; the back end waits for the output register to free.
`default_nettype none

module integer_to_ascii_formatter
   import itaf_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_beat,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_beat
);

   logic                   job_valid;
   job_type                job;
   logic [VALUE_WIDTH-1:0] job_mag;
   logic                   job_take;

   // accept and classify
   itaf_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .job_valid (job_valid),
      .job       (job),
      .job_mag   (job_mag),
      .job_take  (job_take)
   );

   // convert and emit
   itaf_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_mag   (job_mag),
      .job_take  (job_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule

`default_nettype wire

// ===== rtl/itaf_front.sv =====
// front end: accepts input beats, forms sign and magnitude, queues jobs
`default_nettype none

module itaf_front
   import itaf_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_beat,
   output logic                        job_valid,
   output job_type                     job,
   output logic [VALUE_WIDTH-1:0]      job_mag,
   input  wire logic                   job_take
);

   localparam int QDEPTH = 2;
   localparam int CNT_W  = $clog2(QDEPTH + 1);

   logic [63:0]            value_wide;
   logic [VALUE_WIDTH-1:0] value_raw;
   logic                   is_negative;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   push;
   logic                   pop;

   job_type                job_q_ff [QDEPTH];
   logic [VALUE_WIDTH-1:0] mag_q_ff [QDEPTH];
   logic                   wr_ptr_ff;
   logic                   wr_ptr_in;
   logic                   rd_ptr_ff;
   logic                   rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   // read the value at the configured width, take magnitude of signed negatives
   assign value_wide  = {32'd0, req_beat.value};
   assign value_raw   = value_wide[VALUE_WIDTH-1:0];
   assign is_negative = (req_beat.action == FMT_SDEC) && value_raw[VALUE_WIDTH-1];
   assign magnitude   = is_negative ? (~value_raw + VALUE_WIDTH'(1)) : value_raw;

   // queue handshake
   assign req_stall = (count_ff == CNT_W'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != '0);
   assign pop       = job_take && job_valid;
   assign job       = job_q_ff[rd_ptr_ff];
   assign job_mag   = mag_q_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         job_q_ff[wr_ptr_ff] <= '{negative: is_negative, fmt: req_beat.action};
         mag_q_ff[wr_ptr_ff] <= magnitude;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/itaf_back.sv =====
// back end: binary to bcd conversion, leading zero skip and character output
`default_nettype none

module itaf_back
   import itaf_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   input  wire job_type                job,
   input  wire logic [VALUE_WIDTH-1:0] job_mag,
   output logic                        job_take,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_beat
);

   localparam int NIB    = (VALUE_WIDTH + 3) / 4;
   localparam int MAG_W  = NIB * 4;
   localparam int DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int BCD_W  = DIGITS * 4;
   localparam int IDX_W  = $clog2(DIGITS);
   localparam int STEP_W = $clog2(NIB);

   back_state_type         state_ff;
   back_state_type         state_in;
   logic [MAG_W-1:0]       shift_ff;
   logic [MAG_W-1:0]       shift_in;
   logic [BCD_W-1:0]       bcd_ff;
   logic [BCD_W-1:0]       bcd_in;
   logic [STEP_W-1:0]      step_ff;
   logic [STEP_W-1:0]      step_in;
   logic [IDX_W-1:0]       idx_ff;
   logic [IDX_W-1:0]       idx_in;
   logic                   sign_ff;
   logic                   sign_in;
   logic                   upper_ff;
   logic                   upper_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic [COUNT_WIDTH-1:0] total_ff;
   logic [COUNT_WIDTH-1:0] total_in;

   logic [BCD_W-1:0]       dab;
   logic [MAG_W-1:0]       dab_shift;
   logic [IDX_W-1:0]       top_idx;
   logic [3:0]             cur_digit;
   logic                   out_free;

   // double dabble, four magnitude bits per cycle
   always_comb begin
      dab       = bcd_ff;
      dab_shift = shift_ff;
      for (int b = 0; b < 4; b++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (dab[d*4 +: 4] >= 4'd5) begin
               dab[d*4 +: 4] = dab[d*4 +: 4] + 4'd3;
            end
         end
         dab       = {dab[BCD_W-2:0], dab_shift[MAG_W-1]};
         dab_shift = {dab_shift[MAG_W-2:0], 1'b0};
      end
   end

   // highest nonzero digit, digit zero when all are zero
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            top_idx = IDX_W'(d);
         end
      end
   end

   assign cur_digit = bcd_ff[{idx_ff, 2'b00} +: 4];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      sign_in      = sign_ff;
      upper_in     = upper_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      job_take     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               sign_in  = job.negative;
               upper_in = (job.fmt == FMT_HEXU);
               shift_in = MAG_W'(job_mag);
               step_in  = '0;
               if (job.fmt == FMT_SDEC || job.fmt == FMT_UDEC) begin
                  bcd_in   = '0;
                  state_in = ST_CONV;
               end else begin
                  bcd_in   = BCD_W'(job_mag);
                  state_in = ST_NORM;
               end
            end
         end
         ST_CONV: begin
            bcd_in   = dab;
            shift_in = dab_shift;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(NIB - 1)) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            idx_in   = top_idx;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               total_in             = total_ff + COUNT_WIDTH'(1);
               rsp_in.total_emitted = total_ff + COUNT_WIDTH'(1);
               if (sign_ff) begin
                  rsp_in.char_code = CHAR_MINUS;
                  rsp_in.last_char = 1'b0;
                  sign_in          = 1'b0;
               end else begin
                  rsp_in.char_code = digit_char(cur_digit, upper_ff);
                  rsp_in.last_char = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   // working registers and output beat
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      step_ff  <= step_in;
      idx_ff   <= idx_in;
      sign_ff  <= sign_in;
      upper_ff <= upper_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/itaf_checker.sv =====
// port level checks on the formatter output and their bind to the top level
`default_nettype none

module itaf_checker
   import itaf_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_beat
);

   logic                   rsp_fire;
   logic [COUNT_WIDTH-1:0] prev_total_ff;
   logic                   after_last_ff;

   assign rsp_fire = rsp_valid && !rsp_stall;

   // track last count seen and whether a new text starts
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_total_ff <= '0;
         after_last_ff <= 1'b1;
      end else if (rsp_fire) begin
         prev_total_ff <= rsp_beat.total_emitted;
         after_last_ff <= rsp_beat.last_char;
      end
   end

   // output empties after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled beat holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
      else $error("stalled rsp beat changed");

   // running count steps by one per beat
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> rsp_beat.total_emitted == prev_total_ff + COUNT_WIDTH'(1))
      else $error("total_emitted did not step by one");

   // a leading zero only stands alone
   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && after_last_ff && rsp_beat.char_code == HEX_LOWER[0] |-> rsp_beat.last_char)
      else $error("leading zero emitted");

   // a minus sign is never the final character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_beat.char_code == CHAR_MINUS |-> !rsp_beat.last_char)
      else $error("minus sign marked last");

endmodule

bind integer_to_ascii_formatter itaf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_beat  (rsp_beat)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the integer to ascii formatter
module tb_top;
   import itaf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // quiet cycles tolerated before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_VALUES  = 340;
   localparam int DRAIN_CYCLES   = 40;

   // ascii codes used to build digits
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_UPPER = 8'h37; // 'A' minus ten
   localparam logic [7:0] ASCII_LOWER = 8'h57; // 'a' minus ten

   // one directed value, with its text typed in where it is obvious
   typedef struct {
      fmt_type     fmt;
      logic [31:0] value;
      string       text;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_beat;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_beat;

   rsp_type          pending_chars [$];
   logic [31:0]      chars_predicted = '0;
   int unsigned      fail_count = 0;
   int unsigned      quiet_cycles = 0;
   bit               calm = 1'b0;
   directed_row_type directed_rows [22];

   integer_to_ascii_formatter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   always #5 clock = ~clock;

   // text of one value in the chosen format
   function automatic string format_value(fmt_type fmt, logic [31:0] value);
      string       text;
      logic [31:0] mag;
      logic [3:0]  digit;
      logic [7:0]  code;
      bit          minus;
      text  = "";
      minus = (fmt == FMT_SDEC) && value[31];
      mag   = minus ? -value : value;
      do begin
         if (fmt == FMT_SDEC || fmt == FMT_UDEC) begin
            digit = 4'(mag % 32'd10);
            mag   = mag / 32'd10;
         end else begin
            digit = mag[3:0];
            mag   = mag >> 4;
         end
         if (digit < 4'd10)
            code = ASCII_ZERO + 8'(digit);
         else
            code = ((fmt == FMT_HEXU) ? ASCII_UPPER : ASCII_LOWER) + 8'(digit);
         text = {$sformatf("%c", code), text};
      end while (mag != 0);
      if (minus)
         text = {"-", text};
      return text;
   endfunction

   // queue one character beat per letter of the text, advancing the count
   function automatic void expect_text(string text);
      rsp_type beat;
      for (int k = 0; k < text.len(); k++) begin
         chars_predicted    = chars_predicted + 32'd1;
         beat.char_code     = text[k];
         beat.last_char     = (k == text.len() - 1);
         beat.total_emitted = chars_predicted;
         pending_chars.push_back(beat);
      end
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int unsigned roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random value biased toward digit-count and sign boundaries
   function automatic logic [31:0] pick_value();
      logic [31:0] pow;
      pow = 32'd1;
      repeat ($urandom_range(0, 9)) pow = pow * 32'd10;
      case ($urandom_range(0, 9))
         0: return 32'($urandom_range(0, 15));
         1: return 32'd1 << $urandom_range(0, 31);
         2: return (32'd1 << $urandom_range(0, 31)) - 32'd1;
         3: return pow - 32'($urandom_range(0, 1));
         4: return -(pow - 32'($urandom_range(0, 1)));
         5: return 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd2;
         default: return $urandom();
      endcase
   endfunction

   // drive one input beat and record what it should print
   task automatic send_value(fmt_type fmt, logic [31:0] value, string typed);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_beat.action <= fmt;
      req_beat.value  <= value;
      do @(posedge clock); while (req_stall);
      expect_text((typed.len() != 0) ? typed : format_value(fmt, value));
   endtask

   // output back pressure
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         repeat (1 + $urandom_range(0, 5)) @(negedge clock);
         n = idle_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each accepted character beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected character beat %h", rsp_beat);
            fail_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_beat.char_code !== want.char_code) begin
               $error("char_code expected %h got %h", want.char_code, rsp_beat.char_code);
               fail_count++;
            end
            if (rsp_beat.last_char !== want.last_char) begin
               $error("last_char expected %b got %b", want.last_char, rsp_beat.last_char);
               fail_count++;
            end
            if (rsp_beat.total_emitted !== want.total_emitted) begin
               $error("total_emitted expected %0d got %0d",
                      want.total_emitted, rsp_beat.total_emitted);
               fail_count++;
            end
         end
      end
   end

   // hang detection: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // reset, directed values, random values, drain
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_beat  = '0;
      directed_rows = '{
         '{FMT_SDEC, 32'h0000_0000, "0"},
         '{FMT_UDEC, 32'h0000_0000, "0"},
         '{FMT_HEXL, 32'h0000_0000, "0"},
         '{FMT_HEXU, 32'h0000_0000, "0"},
         '{FMT_SDEC, 32'h8000_0000, "-2147483648"},
         '{FMT_SDEC, 32'h7FFF_FFFF, "2147483647"},
         '{FMT_SDEC, 32'hFFFF_FFFF, "-1"},
         '{FMT_UDEC, 32'hFFFF_FFFF, "4294967295"},
         '{FMT_HEXL, 32'hFFFF_FFFF, "ffffffff"},
         '{FMT_HEXU, 32'hFFFF_FFFF, "FFFFFFFF"},
         '{FMT_UDEC, 32'h8000_0000, "2147483648"},
         '{FMT_HEXL, 32'h8000_0000, "80000000"},
         '{FMT_SDEC, 32'h0000_0001, "1"},
         '{FMT_HEXU, 32'h0000_000A, "A"},
         '{FMT_HEXL, 32'h0000_000A, "a"},
         '{FMT_SDEC, 32'h0000_0009, ""},
         '{FMT_SDEC, 32'h0000_000A, ""},
         '{FMT_UDEC, 32'h3B9A_CA00, ""},
         '{FMT_HEXL, 32'hDEAD_BEEF, ""},
         '{FMT_HEXU, 32'h89AB_CDEF, ""},
         '{FMT_SDEC, 32'hC465_3600, ""},
         '{FMT_SDEC, 32'hFFFF_FFF6, ""}
      };
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_value(directed_rows[i].fmt, directed_rows[i].value, directed_rows[i].text);

      for (int i = 0; i < RANDOM_VALUES; i++) begin
         // a stretch with no idling on either side
         calm = (i >= 140 && i < 200);
         send_value(fmt_type'($urandom_range(0, 3)), pick_value(), "");
      end
      calm = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
